>>> rtl/core/ssrq_pkg.sv
// shared types and constants for the sorted store rank query block
`default_nettype none
package ssrq_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS     = 11;
	localparam int IN_VALUE_BITS  = 32;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INSERT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic capture;
		logic set_ovf;
		logic clear;
		logic rd_mid;
		logic step;
		logic rd_prev;
		logic wr_shift;
		logic ins;
		logic resp;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic lo_lt_hi;
		logic ptr_gt_lo;
		logic is_load;
	} status_t;

endpackage
`default_nettype wire

>>> rtl/core/sorted_store_rank_query.sv
// top level of the sorted store rank query block
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------
// command  | start, busy          | kind, value
// result   | done (one cycle)     | count_le, overflowed
//
// clear, a load into a full store and an unused kind are handled in ST_IDLE.
// query: a binary search over the n stored values with at most ceil(log2(n+1))
// probes, each a read and a compare state on the single registered read port.
// load: the same search, then the m entries above the insert place are moved up
// one at a time through that same port, then the value is written.
// reset clears count and overflow mark; the memory needs no clearing pass.
// done is high for one cycle; the receiver cannot stall and busy is already low then.
`default_nettype none
module sorted_store_rank_query #(
	parameter int DEPTH      = ssrq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = ssrq_pkg::VALUE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [1:0]                         kind,
	input  wire logic [ssrq_pkg::IN_VALUE_BITS-1:0] value,
	output logic                                    busy,
	output logic                                    done,
	output logic [ssrq_pkg::COUNT_BITS-1:0]         count_le,
	output logic                                    overflowed
);

	ssrq_pkg::cmd_t    cmd;
	ssrq_pkg::status_t st;

	ssrq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	ssrq_dp #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (kind),
		.value      (value),
		.cmd        (cmd),
		.st         (st),
		.done       (done),
		.count_le   (count_le),
		.overflowed (overflowed)
	);

endmodule
`default_nettype wire

>>> rtl/core/ssrq_ctrl.sv
// controller state machine for the sorted store rank query block
`default_nettype none
module ssrq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        kind,
	input  wire ssrq_pkg::status_t st,
	output ssrq_pkg::cmd_t         cmd,
	output logic                   busy
);

	ssrq_pkg::state_t state_q;
	ssrq_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssrq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = 1'b1;
		case (state_q)
			ssrq_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					case (kind)
						ssrq_pkg::KIND_LOAD: begin
							if (st.full) begin
								cmd.set_ovf = 1'b1;
							end else begin
								cmd.capture = 1'b1;
								state_nx    = ssrq_pkg::ST_SRCH_RD;
							end
						end
						ssrq_pkg::KIND_QUERY: begin
							cmd.capture = 1'b1;
							state_nx    = ssrq_pkg::ST_SRCH_RD;
						end
						ssrq_pkg::KIND_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ssrq_pkg::ST_SRCH_RD: begin
				if (st.lo_lt_hi) begin
					cmd.rd_mid = 1'b1;
					state_nx   = ssrq_pkg::ST_SRCH_CMP;
				end else if (st.is_load) begin
					state_nx = ssrq_pkg::ST_SHIFT_RD;
				end else begin
					state_nx = ssrq_pkg::ST_RESP;
				end
			end
			ssrq_pkg::ST_SRCH_CMP: begin
				cmd.step = 1'b1;
				state_nx = ssrq_pkg::ST_SRCH_RD;
			end
			ssrq_pkg::ST_SHIFT_RD: begin
				if (st.ptr_gt_lo) begin
					cmd.rd_prev = 1'b1;
					state_nx    = ssrq_pkg::ST_SHIFT_WR;
				end else begin
					state_nx = ssrq_pkg::ST_INSERT;
				end
			end
			ssrq_pkg::ST_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				state_nx     = ssrq_pkg::ST_SHIFT_RD;
			end
			ssrq_pkg::ST_INSERT: begin
				cmd.ins  = 1'b1;
				state_nx = ssrq_pkg::ST_IDLE;
			end
			ssrq_pkg::ST_RESP: begin
				cmd.resp = 1'b1;
				state_nx = ssrq_pkg::ST_IDLE;
			end
			default: begin
				state_nx = ssrq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/ssrq_dp.sv
// datapath: sorted value memory, search bounds, shift pointer and result registers
`default_nettype none
module ssrq_dp #(
	parameter int DEPTH      = ssrq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = ssrq_pkg::VALUE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [1:0]                         kind,
	input  wire logic [ssrq_pkg::IN_VALUE_BITS-1:0] value,
	input  wire ssrq_pkg::cmd_t                     cmd,
	output ssrq_pkg::status_t                       st,
	output logic                                    done,
	output logic [ssrq_pkg::COUNT_BITS-1:0]         count_le,
	output logic                                    overflowed
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int EXT_W = VALUE_BITS + ssrq_pkg::IN_VALUE_BITS;

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rdata_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] v_in;
	logic [EXT_W-1:0]      v_ext;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      lo_q;
	logic [CNT_W-1:0]      hi_q;
	logic [CNT_W-1:0]      ptr_q;
	logic [CNT_W-1:0]      ptr_m1;
	logic [CNT_W:0]        mid_sum;
	logic [CNT_W-1:0]      mid;
	logic                  load_q;
	logic                  ovf_q;
	logic                  done_q;
	logic [ssrq_pkg::COUNT_BITS-1:0] cnt_res_q;
	logic [CNT_W+ssrq_pkg::COUNT_BITS-1:0] lo_ext;

	// input value is taken in its low VALUE_BITS bits, zero extended if wider
	assign v_ext   = {{VALUE_BITS{1'b0}}, value};
	assign v_in    = v_ext[VALUE_BITS-1:0];
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];
	assign ptr_m1  = ptr_q - CNT_W'(1);
	assign lo_ext  = {{ssrq_pkg::COUNT_BITS{1'b0}}, lo_q};

	assign st.full      = (count_q == CNT_W'(DEPTH));
	assign st.lo_lt_hi  = (lo_q < hi_q);
	assign st.ptr_gt_lo = (ptr_q > lo_q);
	assign st.is_load   = load_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_shift) begin
			mem[ptr_q[IDX_W-1:0]] <= rdata_q;
		end else if (cmd.ins) begin
			mem[lo_q[IDX_W-1:0]] <= v_q;
		end
		if (cmd.rd_mid) begin
			rdata_q <= mem[mid[IDX_W-1:0]];
		end else if (cmd.rd_prev) begin
			rdata_q <= mem[ptr_m1[IDX_W-1:0]];
		end
	end

	// search and shift bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			v_q    <= v_in;
			load_q <= (kind == ssrq_pkg::KIND_LOAD);
			lo_q   <= '0;
			hi_q   <= count_q;
			ptr_q  <= count_q;
		end else begin
			if (cmd.step) begin
				if (rdata_q <= v_q) begin
					lo_q <= mid + CNT_W'(1);
				end else begin
					hi_q <= mid;
				end
			end
			if (cmd.wr_shift) begin
				ptr_q <= ptr_m1;
			end
		end
		if (cmd.resp) begin
			cnt_res_q <= lo_ext[ssrq_pkg::COUNT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.resp;
			if (cmd.clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (cmd.ins) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (cmd.set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign done       = done_q;
	assign count_le   = cnt_res_q;
	assign overflowed = ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stored count above depth");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> (count_q < CNT_W'(DEPTH)) && (lo_q <= count_q))
		else $error("insert into full store or past count");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_mid |-> (hi_q <= count_q))
		else $error("search read beyond stored entries");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count_q == '0) && !ovf_q)
		else $error("clear left entries or overflow mark");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// testbench for the sorted store rank query block: directed table, full-store phase, random segments
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	localparam int STORE_DEPTH = ssrq_pkg::DEPTH_DEF;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 850;
	localparam int DRAIN_CYCLES = 2200;

	typedef struct {
		logic [ssrq_pkg::COUNT_BITS-1:0] count;
		logic                            ovf;
	} rank_beat_t;

	typedef struct {
		logic [1:0]                      k;
		logic [31:0]                     v;
		bit                              typed;
		logic [ssrq_pkg::COUNT_BITS-1:0] cnt;
		logic                            ovf;
	} dir_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic [1:0]                         kind;
	logic [ssrq_pkg::IN_VALUE_BITS-1:0] value;
	logic                               busy;
	logic                               done;
	logic [ssrq_pkg::COUNT_BITS-1:0]    count_le;
	logic                               overflowed;

	logic [31:0] shadow_store[$];
	logic        shadow_ovf;
	rank_beat_t  rank_q[$];
	dir_row_t    dir_rows[$];
	int          fail_count;
	bit          nogap_mode;

	sorted_store_rank_query u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.kind       (kind),
		.value      (value),
		.busy       (busy),
		.done       (done),
		.count_le   (count_le),
		.overflowed (overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic flag(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// upper bound on the sorted shadow copy
	function automatic int unsigned rank_at_most(input logic [31:0] v);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = shadow_store.size();
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (shadow_store[mid] <= v) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	// one command beat: random gap (none in nogap_mode), wait for acceptance, then update the shadow store
	task automatic send_beat(input logic [1:0] k, input logic [31:0] v, input bit typed = 1'b0,
			input logic [ssrq_pkg::COUNT_BITS-1:0] tc = '0, input logic to = 1'b0);
		int unsigned gap;
		rank_beat_t  want;
		gap = nogap_mode ? 0 : $urandom_range(15);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= k;
		value <= v;
		do @(posedge clk); while (busy);
		case (k)
			ssrq_pkg::KIND_LOAD: begin
				if (shadow_store.size() >= STORE_DEPTH) shadow_ovf = 1'b1;
				else shadow_store.insert(rank_at_most(v), v);
			end
			ssrq_pkg::KIND_QUERY: begin
				want.count = ssrq_pkg::COUNT_BITS'(rank_at_most(v));
				want.ovf   = shadow_ovf;
				if (typed) begin
					want.count = tc;
					want.ovf   = to;
				end
				rank_q.insert(rank_q.size(), want);
			end
			ssrq_pkg::KIND_CLEAR: begin
				shadow_store.delete();
				shadow_ovf = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic add_row(input logic [1:0] k, input logic [31:0] v, input bit typed = 1'b0,
			input logic [ssrq_pkg::COUNT_BITS-1:0] c = '0, input logic o = 1'b0);
		dir_row_t r;
		r.k     = k;
		r.v     = v;
		r.typed = typed;
		r.cnt   = c;
		r.ovf   = o;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	function automatic logic [31:0] pick_query(input logic [31:0] base);
		int unsigned r;
		logic [31:0] s;
		r = $urandom_range(99);
		if (shadow_store.size() != 0) s = shadow_store[$urandom_range(shadow_store.size() - 1)];
		else s = $urandom;
		if (r < 20) return $urandom;
		if (r < 50) return s;
		if (r < 58) return s + 32'd1;
		if (r < 65) return s - 32'd1;
		if (r < 75) return 32'h0000_0000;
		if (r < 85) return 32'hFFFF_FFFF;
		return base + $urandom_range(15);
	endfunction

	always @(posedge clk) begin : result_check
		rank_beat_t want;
		if (arst_n && done) begin
			if (rank_q.size() == 0) begin
				flag($sformatf("result with nothing expected: count_le %0d overflowed %0d",
					count_le, overflowed));
			end else begin
				want = rank_q.pop_front();
				if (count_le !== want.count || overflowed !== want.ovf) begin
					flag($sformatf({"result mismatch: count_le exp %0d got %0d, ",
						"overflowed exp %0d got %0d"},
						want.count, count_le, want.ovf, overflowed));
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned done_items;
		int unsigned target;
		int unsigned loads_left;
		int unsigned tail_queries;
		int unsigned vmode;
		int unsigned r;
		logic [31:0] base;
		logic [31:0] desc_val;
		logic [31:0] v;
		start      <= 1'b0;
		kind       <= ssrq_pkg::KIND_LOAD;
		value      <= '0;
		arst_n     <= 1'b0;
		shadow_ovf = 1'b0;
		fail_count = 0;
		nogap_mode = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		add_row(ssrq_pkg::KIND_QUERY, 32'h0000_0000, 1'b1, 11'd0, 1'b0);
		add_row(ssrq_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, 11'd0, 1'b0);
		add_row(KIND_SPARE,           32'hFFFF_FFFF);
		add_row(ssrq_pkg::KIND_LOAD,  32'h0000_0000);
		add_row(ssrq_pkg::KIND_LOAD,  32'hFFFF_FFFF);
		add_row(ssrq_pkg::KIND_LOAD,  32'h0000_0005);
		add_row(ssrq_pkg::KIND_LOAD,  32'h0000_0005);
		add_row(ssrq_pkg::KIND_QUERY, 32'h0000_0000, 1'b1, 11'd1, 1'b0);
		add_row(ssrq_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, 11'd4, 1'b0);
		add_row(ssrq_pkg::KIND_QUERY, 32'h0000_0004);
		add_row(ssrq_pkg::KIND_QUERY, 32'h0000_0005);
		add_row(ssrq_pkg::KIND_QUERY, 32'hFFFF_FFFE);
		add_row(KIND_SPARE,           32'h0000_0005);
		add_row(ssrq_pkg::KIND_QUERY, 32'h0000_0005);
		add_row(ssrq_pkg::KIND_CLEAR, 32'hA5A5_A5A5);
		add_row(ssrq_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, 11'd0, 1'b0);
		add_row(ssrq_pkg::KIND_LOAD,  32'h8000_0000);
		add_row(ssrq_pkg::KIND_QUERY, 32'h7FFF_FFFF);
		add_row(ssrq_pkg::KIND_QUERY, 32'h8000_0000);
		add_row(ssrq_pkg::KIND_CLEAR, 32'h0000_0000);
		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].k, dir_rows[i].v, dir_rows[i].typed, dir_rows[i].cnt,
				dir_rows[i].ovf);
		end

		// fill the store in ascending order, mostly with pairs of equal values, then overrun it
		for (int i = 0; i < STORE_DEPTH; i++) begin
			if (i == STORE_DEPTH - 1) v = 32'hFFFF_FFFF;
			else v = 32'((i >> 1) * 4_000_000);
			send_beat(ssrq_pkg::KIND_LOAD, v);
			if (i % 128 == 127) send_beat(ssrq_pkg::KIND_QUERY, pick_query(32'd0));
		end
		send_beat(ssrq_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, 11'd1024, 1'b0);
		send_beat(ssrq_pkg::KIND_LOAD, $urandom);
		send_beat(ssrq_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, 11'd1024, 1'b1);
		send_beat(ssrq_pkg::KIND_LOAD, 32'h0000_0000);
		send_beat(ssrq_pkg::KIND_QUERY, 32'h0000_0000);
		send_beat(KIND_SPARE, $urandom);
		send_beat(ssrq_pkg::KIND_QUERY, pick_query(32'd0));
		send_beat(ssrq_pkg::KIND_CLEAR, $urandom);
		send_beat(ssrq_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, 11'd0, 1'b0);

		// random segments: build up a store of random size, query it, mostly clear after
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 80) target = $urandom_range(16);
			else if (r < 95) target = $urandom_range(64, 17);
			else target = $urandom_range(300, 65);
			nogap_mode   = ($urandom_range(3) == 0);
			vmode        = $urandom_range(2);
			base         = $urandom;
			desc_val     = 32'hFFFF_FFFF - $urandom_range(255);
			loads_left   = target;
			tail_queries = $urandom_range(6, 1);
			while (loads_left != 0 || tail_queries != 0) begin
				r = $urandom_range(99);
				if (r < 3) begin
					send_beat(KIND_SPARE, $urandom);
				end else if (r < 55 && loads_left != 0) begin
					r = $urandom_range(99);
					if (r < 5) v = 32'h0000_0000;
					else if (r < 10) v = 32'hFFFF_FFFF;
					else if (vmode == 0) v = $urandom;
					else if (vmode == 1) v = base + $urandom_range(7);
					else begin
						desc_val = desc_val - $urandom_range(3);
						v = desc_val;
					end
					send_beat(ssrq_pkg::KIND_LOAD, v);
					loads_left--;
					done_items++;
				end else begin
					send_beat(ssrq_pkg::KIND_QUERY, pick_query(base));
					if (loads_left == 0) tail_queries--;
					done_items++;
				end
			end
			if ($urandom_range(4) != 0 || shadow_store.size() > 300) begin
				send_beat(ssrq_pkg::KIND_CLEAR, $urandom);
				done_items++;
			end
		end
		start <= 1'b0;

		for (int w = 0; w < 5000 && rank_q.size() != 0; w++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (rank_q.size() != 0) begin
			flag($sformatf("%0d expected results never arrived", rank_q.size()));
		end
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
